// ===== src/sha256_pkg.sv =====
package sha256_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_OFFSET_WORDS = 14;

	typedef logic [WORD_W-1:0] word_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       load_byte;   // write byte into schedule buffer
		logic       pad_byte;    // write 0x80 pad at fill position
		logic       zero_word;   // clear word at word_sel
		logic       len_hi;      // write bit length high word to word 14
		logic       len_lo;      // write bit length low word to word 15
		logic       start_blk;   // copy hash into working vars
		logic       round_en;    // perform one round
		logic       fold;        // add working vars into hash
		logic       init_hash;   // load initial hash, clear length
		logic       add_len;     // bit length += 512
		logic [3:0] word_sel;
		logic [5:0] round_idx;
		logic [2:0] out_sel;
	} sha_cmd_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

endpackage

// ===== src/sha256_datapath.sv =====
module sha256_datapath
	import sha256_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sha_cmd_t cmd,
	input  logic [7:0] byte_in,
	input  logic [5:0] fill,
	output word_t    digest_out
);

	// 16-word sliding schedule window; w_q[0] is the current round's word
	word_t w_q [16];
	word_t v_q [8];
	word_t h_q [8];
	logic [63:0] len_q;

	word_t s0, s1, w_new, t1, t2, e, a;
	logic [63:0] total;
	logic [3:0] widx;
	logic [1:0] bsel;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[cmd.round_idx] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		total = len_q + {55'd0, fill, 3'd0};
		widx = fill[5:2];
		bsel = fill[1:0];
		digest_out = h_q[cmd.out_sel];
	end

	always_ff @(posedge clk) begin
		if (cmd.pad_byte) begin
			// bytes after the pad in its word must read zero
			unique case (bsel)
				2'd0: w_q[widx] <= {8'h80, 24'd0};
				2'd1: w_q[widx][23:0] <= {8'h80, 16'd0};
				2'd2: w_q[widx][15:0] <= {8'h80, 8'd0};
				default: w_q[widx][7:0] <= 8'h80;
			endcase
		end else if (cmd.load_byte) begin
			unique case (bsel)
				2'd0: w_q[widx][31:24] <= byte_in;
				2'd1: w_q[widx][23:16] <= byte_in;
				2'd2: w_q[widx][15:8]  <= byte_in;
				default: w_q[widx][7:0] <= byte_in;
			endcase
		end else if (cmd.zero_word) begin
			w_q[cmd.word_sel] <= '0;
		end else if (cmd.len_hi) begin
			w_q[LEN_OFFSET_WORDS] <= total[63:32];
		end else if (cmd.len_lo) begin
			w_q[LEN_OFFSET_WORDS+1] <= total[31:0];
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_blk) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
			len_q <= '0;
		end else begin
			if (cmd.init_hash) begin
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
				len_q <= '0;
			end else begin
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.add_len) len_q <= len_q + 64'd512;
			end
		end
	end

endmodule

// ===== src/sha256_ctrl.sv =====
module sha256_ctrl
	import sha256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       byte_valid,
	input  logic       end_of_message,
	output logic [5:0] fill,
	output sha_cmd_t   cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_idx
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_ROUND, ST_FOLD, ST_PAD, ST_LEN, ST_OUT
	} state_t;

	state_t state_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [3:0] zw_q;
	logic       fin_q;   // message end pending
	logic       last_q;  // block in flight is the final one
	logic       ovf_q;   // block in flight is a pad block with no room for the length
	logic       lenhi_q;
	logic       out_v_q;
	logic [2:0] oidx_q;

	logic take;
	assign in_ready = (state_q == ST_IDLE);
	assign take = in_valid && in_ready;
	assign fill = fill_q;
	assign out_valid = out_v_q;
	assign out_idx = oidx_q;

	always_comb begin
		cmd = '0;
		cmd.round_idx = rnd_q;
		cmd.word_sel = zw_q;
		cmd.out_sel = oidx_q;
		unique case (state_q)
			ST_IDLE: cmd.load_byte = take && byte_valid;
			ST_START: cmd.start_blk = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_FOLD: begin
				cmd.fold = 1'b1;
				cmd.add_len = !last_q && !ovf_q;
			end
			ST_PAD: begin
				if (zw_q == 4'd0 && !lenhi_q) cmd.pad_byte = 1'b1;
				else cmd.zero_word = 1'b1;
			end
			ST_LEN: begin
				cmd.len_hi = !lenhi_q;
				cmd.len_lo = lenhi_q;
			end
			ST_OUT: cmd.init_hash = out_v_q && out_ready && oidx_q == 3'd7;
			default: ;
		endcase
	end

	// ST_PAD: writes the pad at fill, then zeros words (fill/4+1 .. 13, or .. 15 if no room for length);
	// a second padding block zeros from word 0; lenhi_q doubles as "pad written" flag there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			rnd_q <= '0;
			zw_q <= '0;
			fin_q <= 1'b0;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
			lenhi_q <= 1'b0;
			out_v_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) begin
					if (byte_valid) fill_q <= fill_q + 6'd1;
					fin_q <= end_of_message;
					if (byte_valid && fill_q == 6'd63) begin
						state_q <= ST_START;
						last_q <= 1'b0;
					end else if (end_of_message) begin
						state_q <= ST_PAD;
						zw_q <= '0;
						lenhi_q <= 1'b0;
					end
				end
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (last_q) begin
						state_q <= ST_OUT;
						out_v_q <= 1'b1;
						oidx_q <= '0;
					end else if (ovf_q) begin
						// second padding block: zeros then length, fill_q kept
						state_q <= ST_PAD;
						lenhi_q <= 1'b1;
						zw_q <= '0;
						ovf_q <= 1'b0;
					end else if (fin_q) begin
						// full data block ended the message: pad a fresh block
						state_q <= ST_PAD;
						lenhi_q <= 1'b0;
						zw_q <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (!lenhi_q) begin
						// pad byte just written
						ovf_q <= (fill_q >= 6'd56);
						if (fill_q[5:2] == 4'd15) begin
							state_q <= ST_START;
							last_q <= 1'b0;
						end else if (fill_q < 6'd56 && fill_q[5:2] >= 4'd13) begin
							state_q <= ST_LEN;
						end else begin
							lenhi_q <= 1'b1;
							zw_q <= fill_q[5:2] + 4'd1;
						end
					end else begin
						zw_q <= zw_q + 4'd1;
						if (!ovf_q && zw_q == 4'd13) begin
							state_q <= ST_LEN;
							lenhi_q <= 1'b0;
						end else if (ovf_q && zw_q == 4'd15) begin
							state_q <= ST_START;
							last_q <= 1'b0;
						end
					end
				end
				ST_LEN: begin
					lenhi_q <= 1'b1;
					if (lenhi_q) begin
						state_q <= ST_START;
						last_q <= 1'b1;
					end
				end
				ST_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						out_v_q <= 1'b0;
						state_q <= ST_IDLE;
						fill_q <= '0;
						fin_q <= 1'b0;
						last_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/sha256_message_hasher_core.sv =====
// SHA-256 hasher. Bytes stream in on s_axis, one per transfer, with tuser
// bit 0 marking a real byte and tlast ending the message (a tlast transfer
// with no byte is legal, also for the empty message). The 64th byte of a
// block starts a compression (one round per cycle on a single shared round
// unit and a 16-word rolling schedule window), during which input is held
// off. Ending a message costs padding (clearing words), one or two
// compressions, and then eight digest words on m_axis, word 0 (most
// significant) first, tlast on word 7. After the last word the hash state
// returns to the initial values.
module sha256_message_hasher_core
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] msg_byte
	input  logic        s_axis_tuser,  // [0] byte_valid
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, zeros
	output logic        m_axis_tlast   // last_word
);

	sha_cmd_t   cmd;
	logic [5:0] fill;
	logic [2:0] out_idx;
	word_t      digest;

	sha256_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.byte_valid(s_axis_tuser),
		.end_of_message(s_axis_tlast),
		.fill(fill),
		.cmd(cmd),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_idx(out_idx)
	);

	sha256_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.byte_in(s_axis_tdata),
		.fill(fill),
		.digest_out(digest)
	);

	assign m_axis_tdata = {5'd0, out_idx, digest};
	assign m_axis_tlast = (out_idx == 3'd7);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import sha256_pkg::*;

	typedef struct {
		word_t    digest;
		logic [2:0] index;
		logic     last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	sha256_message_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	localparam word_t START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// predictor state
	word_t       chain [8];
	logic [7:0]  buffer [64];
	int unsigned fill;
	logic [63:0] bits_done;
	digest_beat_t pending_digest [$];

	int errors;
	int burst_left;
	int hold_left;
	int stall_pct;
	int cycle_cnt;

	function automatic word_t ror(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one SHA-256 compression of buffer into chain
	function automatic void compress_buffer();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int r = 0; r < 16; r++)
			w[r] = {buffer[4*r], buffer[4*r+1], buffer[4*r+2], buffer[4*r+3]};
		for (int r = 16; r < 64; r++)
			w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
				+ (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
		v = chain;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int r = 0; r < 8; r++)
			chain[r] += v[r];
	endfunction

	// absorbs one accepted transfer; queues eight digest words on end of message
	function automatic void absorb_transfer(logic [7:0] b, logic valid, logic eom);
		int unsigned i;
		logic [63:0] total;
		digest_beat_t beat;
		if (valid) begin
			buffer[fill] = b;
			fill++;
			if (fill == 64) begin
				compress_buffer();
				bits_done += 64'd512;
				fill = 0;
			end
		end
		if (!eom)
			return;
		i = fill;
		buffer[i++] = 8'h80;
		while (i < 64)
			buffer[i++] = 8'h00;
		if (fill >= 56) begin
			compress_buffer();
			for (int k = 0; k < 56; k++)
				buffer[k] = 8'h00;
		end
		total = bits_done + 64'(fill) * 8;
		for (int k = 0; k < 8; k++)
			buffer[56+k] = total[63-8*k -: 8];
		compress_buffer();
		for (int k = 0; k < 8; k++) begin
			beat.digest = chain[k];
			beat.index  = 3'(k);
			beat.last   = (k == 7);
			pending_digest.push_back(beat);
		end
		chain = START_H;
		fill = 0;
		bits_done = '0;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sends one transfer, with bursty gaps ahead of it
	task automatic send_item(logic [7:0] b, logic valid, logic eom);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= valid;
		s_axis_tlast  <= eom;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		absorb_transfer(b, valid, eom);
	endtask

	// message of len random bytes; end marker rides on the last byte or stands alone
	task automatic send_message(int len, bit marker_alone);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);   // idle transfer, no effect
			send_item(8'($urandom), 1'b1, !marker_alone && n == len - 1);
		end
		if (marker_alone || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// receiver: stall pattern of its own, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_digest.size() == 0) begin
				$error("unexpected digest word %h", m_axis_tdata[31:0]);
				errors++;
			end else begin
				digest_beat_t exp_beat;
				exp_beat = pending_digest.pop_front();
				if (m_axis_tdata[31:0] !== exp_beat.digest) begin
					$error("digest_word: expected %h, got %h", exp_beat.digest,
						m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[34:32] !== exp_beat.index) begin
					$error("word_index: expected %0d, got %0d", exp_beat.index,
						m_axis_tdata[34:32]);
					errors++;
				end
				if (m_axis_tlast !== exp_beat.last) begin
					$error("last_word: expected %b, got %b", exp_beat.last, m_axis_tlast);
					errors++;
				end
			end
		end
		if (cycle_cnt % 64 == 0)
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// empty message, end marker without a byte, idle transfers, extreme bytes
	task automatic test_directed();
		send_item(8'hff, 1'b0, 1'b1);           // empty message
		send_item(8'h00, 1'b0, 1'b0);           // idle transfers
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);           // "abc"
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);           // marker without byte
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);           // single 0xff byte
		send_item(8'h00, 1'b1, 1'b1);           // single 0x00 byte
	endtask

	// output held off for long while input streams: core must stall its input
	task automatic test_backpressure();
		hold_left = 600;
		send_message(3, 1'b0);
		send_message(2, 1'b1);
		send_message(5, 1'b0);
	endtask

	// random messages, lengths biased to the one- and two-block padding edges
	task automatic test_random_messages();
		int sent;
		int len;
		sent = 0;
		while (sent < 330) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(54, 57);
				1: len = $urandom_range(62, 66);
				2: len = $urandom_range(118, 130);
				default: len = $urandom_range(0, 20);
			endcase
			send_message(len, $urandom_range(0, 2) == 0);
			sent += len + 1;
		end
	endtask

	initial begin
		errors = 0;
		burst_left = 0;
		hold_left = 0;
		stall_pct = 0;
		cycle_cnt = 0;
		chain = START_H;
		fill = 0;
		bits_done = '0;
		for (int k = 0; k < 64; k++)
			buffer[k] = 8'h00;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_messages();

		s_axis_tvalid <= 1'b0;
		while (pending_digest.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sha256_pkg.sv
src/sha256_datapath.sv
src/sha256_ctrl.sv
src/sha256_message_hasher_core.sv
tb/testbench.sv
